// ===== src/ffgp_pkg.sv =====
// Shared types, constants and helper functions for the first-fit grid placer.
// Depends on nothing; imported by every module of the block.
package ffgp_pkg;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int COL_W     = $clog2(GRID_COLS);
	localparam int HGT_W     = 6;
	localparam int WID_W     = 8;
	localparam int POS_W     = 6;
	localparam int RUN_W     = HGT_W;

	localparam logic MODE_PLACE = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef logic [GRID_COLS-1:0] grid_row_t;
	typedef logic [RUN_W-1:0]     run_t;

	localparam run_t RUN_MAX = '1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ZERO,
		ST_RD,
		ST_UPD,
		ST_WIN,
		ST_PICK,
		ST_MRD,
		ST_MWR
	} ffgp_state_t;

	typedef struct packed {
		logic clr;
		logic upd;
		logic win;
	} ffgp_scan_ctl_t;

	// Bit c set when ok[c +: w] is all ones; log-step doubling over the bits of w.
	function automatic grid_row_t win_fn(input grid_row_t ok, input logic [WID_W-1:0] w);
		grid_row_t      acc;
		grid_row_t      pw;
		logic [WID_W:0] sh;
		acc = '1;
		pw  = ok;
		sh  = '0;
		for (int b = 0; b < WID_W; b++) begin
			if (w[b]) begin
				acc = acc & (pw >> sh);
				sh  = sh + ((WID_W+1)'(1) << b);
			end
			pw = pw & (pw >> ((WID_W+1)'(1) << b));
		end
		return acc;
	endfunction

endpackage

// ===== src/first_fit_grid_rect_placer.sv =====
// Top level: first-fit rectangle placer over an occupancy grid held in one RAM.
// Depends on ffgp_pkg and ffgp_col_scan.
// Place: scans bottom rows in order through the RD, UPD, WIN and PICK states, then marks each
// covered row with an MRD read and an MWR write. Clear rewrites every row; zero-size place uses ST_ZERO.
// One transaction at a time; done is a one-cycle strobe and cannot be held off.
// Reset runs a clearing pass over every grid row with busy high.
module first_fit_grid_rect_placer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        mode,
	input  logic [ffgp_pkg::HGT_W-1:0]  rect_height,
	input  logic [ffgp_pkg::WID_W-1:0]  rect_width,
	output logic                        done,
	output logic                        placed,
	output logic [ffgp_pkg::POS_W-1:0]  top_row,
	output logic [ffgp_pkg::POS_W-1:0]  left_col
);
	import ffgp_pkg::*;

	localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(GRID_ROWS - 1);
	localparam logic [ROW_W-1:0] SCAN_LAST = ROW_W'(GRID_ROWS - 2);

	ffgp_state_t       state_q, state_d;
	logic [ROW_W-1:0]  row_q;
	logic [HGT_W-1:0]  cnt_q;
	logic              clr_rep_q;
	logic              done_q;
	logic [HGT_W-1:0]  h_q;
	logic [WID_W-1:0]  w_q;
	grid_row_t         mask_q;
	logic              placed_q;
	logic [POS_W-1:0]  top_q;
	logic [POS_W-1:0]  left_q;

	grid_row_t         grid_mem [GRID_ROWS];
	grid_row_t         rdata_q;
	logic              mem_we;
	logic [ROW_W-1:0]  mem_addr;
	grid_row_t         mem_wd;

	ffgp_scan_ctl_t    scan_ctl;
	logic              found;
	logic [COL_W-1:0]  col;
	logic [8:0]        top_ext;
	logic [ROW_W-1:0]  top_w;
	grid_row_t         ones;
	grid_row_t         mask_w;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_addr] <= mem_wd;
		end
		rdata_q <= grid_mem[mem_addr];
	end

	ffgp_col_scan u_scan (
		.clk      (clk),
		.ctl      (scan_ctl),
		.row_data (rdata_q),
		.rect_h   (h_q),
		.rect_w   (w_q),
		.found    (found),
		.col      (col)
	);

	assign top_ext = 9'(row_q) + 9'd1 - 9'(h_q);
	assign top_w   = top_ext[ROW_W-1:0];
	assign ones    = '1;
	assign mask_w  = (~(ones << w_q)) << col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		mem_addr = row_q;
		mem_wd   = '0;
		scan_ctl = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (row_q == LAST_ROW) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (mode == MODE_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (rect_height == '0 || rect_width == '0) begin
						state_d = ST_ZERO;
					end else begin
						state_d      = ST_RD;
						scan_ctl.clr = 1'b1;
					end
				end
			end
			ST_ZERO: state_d = ST_IDLE;
			ST_RD:   state_d = ST_UPD;
			ST_UPD: begin
				scan_ctl.upd = 1'b1;
				state_d      = ST_WIN;
			end
			ST_WIN: begin
				scan_ctl.win = 1'b1;
				state_d      = ST_PICK;
			end
			ST_PICK: begin
				if (found) begin
					state_d = ST_MRD;
				end else if (row_q == SCAN_LAST) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_MRD: state_d = ST_MWR;
			ST_MWR: begin
				mem_we = 1'b1;
				mem_wd = rdata_q | mask_q;
				state_d = (cnt_q == HGT_W'(1)) ? ST_IDLE : ST_MRD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			cnt_q     <= '0;
			clr_rep_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					row_q <= row_q + ROW_W'(1);
					if (row_q == LAST_ROW) begin
						row_q     <= '0;
						done_q    <= clr_rep_q;
						clr_rep_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						row_q     <= '0;
						clr_rep_q <= (mode == MODE_CLEAR);
					end
				end
				ST_ZERO: done_q <= 1'b1;
				ST_PICK: begin
					if (found) begin
						row_q <= top_w;
						cnt_q <= h_q;
					end else if (row_q == SCAN_LAST) begin
						done_q <= 1'b1;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				ST_MWR: begin
					row_q <= row_q + ROW_W'(1);
					cnt_q <= cnt_q - HGT_W'(1);
					if (cnt_q == HGT_W'(1)) begin
						done_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_CLEAR: begin
				placed_q <= 1'b0;
				top_q    <= '0;
				left_q   <= '0;
			end
			ST_IDLE: begin
				if (start) begin
					h_q <= rect_height;
					w_q <= rect_width;
				end
			end
			ST_ZERO: begin
				placed_q <= (9'(w_q) < 9'(GRID_COLS));
				top_q    <= '0;
				left_q   <= '0;
			end
			ST_PICK: begin
				if (found) begin
					placed_q <= 1'b1;
					top_q    <= POS_W'(top_w);
					left_q   <= POS_W'(col);
					mask_q   <= mask_w;
				end else begin
					placed_q <= 1'b0;
					top_q    <= '0;
					left_q   <= '0;
				end
			end
			default: ;
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign placed   = placed_q;
	assign top_row  = top_q;
	assign left_col = left_q;

endmodule

// ===== src/ffgp_col_scan.sv =====
// Per-column free-run counters and window search for one grid row at a time.
// Depends on ffgp_pkg.
module ffgp_col_scan (
	input  logic                         clk,
	input  ffgp_pkg::ffgp_scan_ctl_t     ctl,
	input  ffgp_pkg::grid_row_t          row_data,
	input  logic [ffgp_pkg::HGT_W-1:0]   rect_h,
	input  logic [ffgp_pkg::WID_W-1:0]   rect_w,
	output logic                         found,
	output logic [ffgp_pkg::COL_W-1:0]   col
);
	import ffgp_pkg::*;

	run_t      runs_q [GRID_COLS];
	run_t      runs_nxt [GRID_COLS];
	grid_row_t ok;
	grid_row_t win_q;

	always_comb begin
		for (int c = 0; c < GRID_COLS; c++) begin
			if (row_data[c]) begin
				runs_nxt[c] = '0;
			end else if (runs_q[c] == RUN_MAX) begin
				runs_nxt[c] = RUN_MAX;
			end else begin
				runs_nxt[c] = runs_q[c] + run_t'(1);
			end
			ok[c] = (c < GRID_COLS - 1) && (runs_q[c] >= rect_h);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < GRID_COLS; c++) begin
			if (ctl.clr) begin
				runs_q[c] <= '0;
			end else if (ctl.upd) begin
				runs_q[c] <= runs_nxt[c];
			end
		end
		if (ctl.win) begin
			win_q <= win_fn(ok, rect_w);
		end
	end

	// lowest set column wins
	always_comb begin
		found = 1'b0;
		col   = '0;
		for (int c = GRID_COLS - 1; c >= 0; c--) begin
			if (win_q[c]) begin
				found = 1'b1;
				col   = COL_W'(c);
			end
		end
	end

endmodule

// ===== src/ffgp_check.sv =====
// Port-level checker for the first-fit grid placer, bound to the top level.
// Depends on ffgp_pkg for field widths.
module ffgp_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        mode,
	input logic [ffgp_pkg::HGT_W-1:0]  rect_height,
	input logic [ffgp_pkg::WID_W-1:0]  rect_width,
	input logic                        done,
	input logic                        placed,
	input logic [ffgp_pkg::POS_W-1:0]  top_row,
	input logic [ffgp_pkg::POS_W-1:0]  left_col
);
	import ffgp_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while still busy");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !placed) |-> (top_row == '0 && left_col == '0))
		else $error("unplaced result carries a nonzero corner");

endmodule

bind first_fit_grid_rect_placer ffgp_check u_ffgp_check (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for first_fit_grid_rect_placer: random and directed place/clear traffic.
// A scoreboard class mirrors the occupancy grid and checks every done strobe in order.
// Depends on ffgp_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
	import ffgp_pkg::*;

	class placement_scoreboard;
		typedef struct {
			logic             placed;
			logic [POS_W-1:0] row;
			logic [POS_W-1:0] col;
		} placement_t;

		grid_row_t  grid [GRID_ROWS];
		placement_t pending [$];
		int         faults;
		int         reported;
		int         n_placed;
		int         n_nofit;
		int         n_clears;

		function new();
			foreach (grid[i]) grid[i] = '0;
			faults   = 0;
			reported = 0;
			n_placed = 0;
			n_nofit  = 0;
			n_clears = 0;
		endfunction

		function void note_request(logic m, logic [HGT_W-1:0] h, logic [WID_W-1:0] w);
			placement_t e;
			grid_row_t  span;
			bit         hit;
			bit         fits;
			e.placed = 1'b0;
			e.row    = '0;
			e.col    = '0;
			if (m == MODE_CLEAR) begin
				foreach (grid[i]) grid[i] = '0;
				n_clears++;
			end else begin
				hit = 1'b0;
				for (int r = 0; r + h < GRID_ROWS && !hit; r++) begin
					for (int c = 0; c + w < GRID_COLS && !hit; c++) begin
						span = ((grid_row_t'(1) << w) - grid_row_t'(1)) << c;
						fits = 1'b1;
						for (int k = 0; k < h; k++)
							if ((grid[r+k] & span) != '0) fits = 1'b0;
						if (fits) begin
							for (int k = 0; k < h; k++) grid[r+k] |= span;
							hit      = 1'b1;
							e.placed = 1'b1;
							e.row    = r[POS_W-1:0];
							e.col    = c[POS_W-1:0];
						end
					end
				end
				if (hit) n_placed++;
				else n_nofit++;
			end
			pending.insert(pending.size(), e);
		endfunction

		function void check_result(logic p, logic [POS_W-1:0] r, logic [POS_W-1:0] c);
			placement_t e;
			if (pending.size() == 0) begin
				faults++;
				if (reported < 10) begin
					reported++;
					$display("%0t: unexpected done: placed=%0b row=%0d col=%0d", $realtime, p, r, c);
				end
			end else begin
				e = pending.pop_front();
				if (p !== e.placed || r !== e.row || c !== e.col) begin
					faults++;
					if (reported < 10) begin
						reported++;
						$display("%0t: mismatch: expected placed=%0b row=%0d col=%0d, got placed=%0b row=%0d col=%0d",
							$realtime, e.placed, e.row, e.col, p, r, c);
					end
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               mode;
	logic [HGT_W-1:0]   rect_height;
	logic [WID_W-1:0]   rect_width;
	logic               done;
	logic               placed;
	logic [POS_W-1:0]   top_row;
	logic [POS_W-1:0]   left_col;

	placement_scoreboard sb;

	first_fit_grid_rect_placer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.rect_height (rect_height),
		.rect_width  (rect_width),
		.done        (done),
		.placed      (placed),
		.top_row     (top_row),
		.left_col    (left_col)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(placed, top_row, left_col);
	end

	// Hold the request until the block takes it.
	task automatic send_request(input logic m, input logic [HGT_W-1:0] h,
			input logic [WID_W-1:0] w);
		start       <= 1'b1;
		mode        <= m;
		rect_height <= h;
		rect_width  <= w;
		do @(posedge clk); while (busy);
		sb.note_request(m, h, w);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_random_request();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			send_request(MODE_CLEAR, HGT_W'($urandom), WID_W'($urandom));
		else if (sel < 70)
			send_request(MODE_PLACE, HGT_W'($urandom_range(1, 6)), WID_W'($urandom_range(1, 10)));
		else if (sel < 80)
			send_request(MODE_PLACE, HGT_W'($urandom_range(1, 63)), WID_W'($urandom_range(1, 63)));
		else if (sel < 85)
			send_request(MODE_PLACE, HGT_W'($urandom), WID_W'($urandom_range(64, 255)));
		else if (sel < 90)
			send_request(MODE_PLACE, HGT_W'($urandom_range(0, 1) ? 0 : $urandom),
				WID_W'($urandom_range(0, 1) ? 0 : $urandom_range(0, 70)));
		else
			send_request(MODE_PLACE, HGT_W'($urandom_range(32, 63)), WID_W'($urandom_range(1, 8)));
	endtask

	initial begin
		int left;
		int burst;
		sb          = new();
		arst_n      = 1'b0;
		start       = 1'b0;
		mode        = MODE_PLACE;
		rect_height = '0;
		rect_width  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MODE_PLACE, 6'd63, 8'd63);
		send_request(MODE_PLACE, 6'd1, 8'd1);
		send_request(MODE_PLACE, 6'd0, 8'd0);
		send_request(MODE_CLEAR, 6'd63, 8'd255);
		send_request(MODE_PLACE, 6'd0, 8'd5);
		send_request(MODE_PLACE, 6'd3, 8'd0);
		send_request(MODE_PLACE, 6'd1, 8'd64);
		send_request(MODE_PLACE, 6'd1, 8'd255);
		send_request(MODE_PLACE, 6'd0, 8'd128);
		hold_off(7);
		send_request(MODE_PLACE, 6'd63, 8'd1);
		send_request(MODE_PLACE, 6'd1, 8'd63);
		send_request(MODE_PLACE, 6'd1, 8'd62);
		send_request(MODE_PLACE, 6'd62, 8'd1);
		send_request(MODE_PLACE, 6'd1, 8'd1);
		send_request(MODE_PLACE, 6'd1, 8'd1);
		send_request(MODE_PLACE, 6'd32, 8'd32);
		send_request(MODE_PLACE, 6'd31, 8'd31);
		send_request(MODE_PLACE, 6'd40, 8'd2);
		send_request(MODE_CLEAR, 6'd0, 8'd0);
		send_request(MODE_PLACE, 6'd5, 8'd7);
		send_request(MODE_PLACE, 6'd5, 8'd7);
		hold_off(2);

		left = 1000;
		while (left > 0) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
			for (int i = 0; i < burst && left > 0; i++) begin
				send_random_request();
				left--;
			end
			case ($urandom_range(0, 3))
				0: hold_off(0);
				1: hold_off($urandom_range(100, 400));
				default: hold_off($urandom_range(1, 12));
			endcase
		end

		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		$display("Ran %0d requests: %0d placed, %0d without a fit, %0d grid clears.",
			sb.n_placed + sb.n_nofit + sb.n_clears, sb.n_placed, sb.n_nofit, sb.n_clears);
		$display("Mismatches or stray results: %0d, results still owed: %0d.",
			sb.faults, sb.pending.size());
		if (sb.faults == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Timed out waiting on the block.");
		$display("Regression FAIL");
		$finish;
	end

endmodule
